### rtl/aldk_pkg.sv
// ----------------------------------------------------------------------------
// aldk_pkg: shared types and constants of the ladder key decoder
// Key and event codes, register indexes, ladder voltage table and reset
// values of the configuration registers.
// ----------------------------------------------------------------------------
package aldk_pkg;

   // converter scaling: mv = code * MV_FULL_SCALE / 2**ADC_BITS
   localparam int ADC_BITS      = 10;
   localparam int MV_BITS       = 11;
   localparam int TOL_BITS      = 10;
   localparam int MS_BITS       = 16;
   localparam int STAMP_BITS    = 32;
   localparam int MV_FULL_SCALE = 1800;
   localparam int TIME_WIDTH_DEFAULT = 32;

   typedef logic [2:0] key_type;
   typedef logic [1:0] event_type;

   localparam key_type KEY_UP     = 3'd0;
   localparam key_type KEY_DOWN   = 3'd1;
   localparam key_type KEY_LEFT   = 3'd2;
   localparam key_type KEY_RIGHT  = 3'd3;
   localparam key_type KEY_CENTER = 3'd4;
   localparam key_type KEY_REC    = 3'd5;
   localparam key_type KEY_NONE   = 3'd7;

   localparam event_type EV_PRESS   = 2'd0;
   localparam event_type EV_REPEAT  = 2'd1;
   localparam event_type EV_RELEASE = 2'd2;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_ENABLE    = 3'd0;
   localparam csr_index_type CSR_IDLE_THR  = 3'd1;
   localparam csr_index_type CSR_TOLERANCE = 3'd2;
   localparam csr_index_type CSR_INIT_DLY  = 3'd3;
   localparam csr_index_type CSR_REP_PER   = 3'd4;

   localparam logic [MV_BITS-1:0]  IDLE_THR_RESET  = 11'd135;
   localparam logic [TOL_BITS-1:0] TOLERANCE_RESET = 10'd80;
   localparam logic [MS_BITS-1:0]  INIT_DLY_RESET  = 16'd500;
   localparam logic [MS_BITS-1:0]  REP_PER_RESET   = 16'd100;

   // ladder taps, searched in this order; first hit wins
   localparam int LADDER_TAPS = 7;
   localparam logic [MV_BITS-1:0] LADDER_MV [LADDER_TAPS] = '{
      11'd800, 11'd1000, 11'd1200, 11'd1400, 11'd1600, 11'd390, 11'd1780
   };
   localparam key_type LADDER_KEY [LADDER_TAPS] = '{
      KEY_UP, KEY_LEFT, KEY_RIGHT, KEY_CENTER, KEY_DOWN, KEY_REC, KEY_LEFT
   };

   typedef struct packed {
      logic [MV_BITS-1:0]  idle_threshold_mv;
      logic [TOL_BITS-1:0] match_tolerance_mv;
   } match_cfg_type;

endpackage

### rtl/aldk_classify.sv
// ----------------------------------------------------------------------------
// aldk_classify: converter code to key
// Scales the code to millivolts, applies the idle threshold and matches
// against the ladder taps in parallel, first hit wins.
// ----------------------------------------------------------------------------
module aldk_classify (
   input  logic [aldk_pkg::ADC_BITS-1:0] adc_code,
   input  logic                          sample_ok,
   input  aldk_pkg::match_cfg_type       match_cfg,
   output aldk_pkg::key_type             key
);
   import aldk_pkg::*;

   localparam int PROD_BITS = ADC_BITS + MV_BITS;

   logic [PROD_BITS-1:0]   product;
   logic [MV_BITS-1:0]     mv;
   logic [LADDER_TAPS-1:0] hit;

   assign product = PROD_BITS'(adc_code) * PROD_BITS'(MV_FULL_SCALE);
   assign mv      = product[PROD_BITS-1:ADC_BITS];

   for (genvar i = 0; i < LADDER_TAPS; i++) begin : g_tap
      logic signed [MV_BITS:0] diff;
      logic        [MV_BITS-1:0] delta;
      assign diff = $signed({1'b0, mv}) - $signed({1'b0, LADDER_MV[i]});
      assign delta = diff[MV_BITS] ? MV_BITS'(-diff) : diff[MV_BITS-1:0];
      assign hit[i] = delta <= MV_BITS'(match_cfg.match_tolerance_mv);
   end

   always_comb begin
      key = KEY_NONE;
      // walk from the last tap so the earliest hit is left standing
      for (int i = LADDER_TAPS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            key = LADDER_KEY[i];
         end
      end
      if (!sample_ok || (mv < match_cfg.idle_threshold_mv)) begin
         key = KEY_NONE;
      end
   end

endmodule

### rtl/adc_ladder_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder_unit: resistor ladder keypad decoder
// Debounces ladder samples over two polls and emits press, repeat and
// release events.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: adc_code, time_ms; tuser: sample_ok
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: key_code; tuser: event_kind
//   csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
// One poll word per cycle sustained while the result side is not stalled;
// a poll passes the input register, then classify and state update into the
// result register. Decoder state changes together with the result register,
// so back-to-back polls see each other's effect. Reset clears control state
// and loads register defaults. A stalled result holds the pipe; csr_ready is
// always high.
// ----------------------------------------------------------------------------
module adc_ladder_key_decoder_unit #(
   parameter int TIME_WIDTH = aldk_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,   // adc_code[9:0], time_ms[41:10]
   input  logic                          req_tuser,   // sample_ok
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // key_code[2:0]
   output aldk_pkg::event_type           rsp_tuser,   // event_kind[1:0]
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  aldk_pkg::csr_index_type       csr_index,
   input  logic [aldk_pkg::MS_BITS-1:0]  csr_data
);
   import aldk_pkg::*;

   // configuration
   logic                 enable_ff;
   logic [MV_BITS-1:0]   idle_thr_ff;
   logic [TOL_BITS-1:0]  tolerance_ff;
   logic [MS_BITS-1:0]   init_dly_ff;
   logic [MS_BITS-1:0]   rep_per_ff;

   // input register
   logic                  in_vld_ff;
   logic [ADC_BITS-1:0]   code_ff;
   logic                  ok_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   // decoder state
   key_type               prev_key_ff, prev_key_in;
   key_type               acc_key_ff, acc_key_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;

   // result register
   logic      out_vld_ff;
   event_type out_kind_ff, out_kind_in;
   key_type   out_key_ff, out_key_in;

   logic                  advance;
   logic                  fire;
   logic                  emit;
   key_type               seen;
   match_cfg_type         match_cfg;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  reached;

   assign csr_ready  = 1'b1;
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;
   assign fire       = in_vld_ff && advance;

   assign match_cfg.idle_threshold_mv  = idle_thr_ff;
   assign match_cfg.match_tolerance_mv = tolerance_ff;

   aldk_classify u_classify (
      .adc_code  (code_ff),
      .sample_ok (ok_ff),
      .match_cfg (match_cfg),
      .key       (seen)
   );

   assign now     = TIME_WIDTH'(stamp_ff);
   assign elapsed = now - deadline_ff;
   assign reached = !elapsed[TIME_WIDTH-1];

   always_comb begin
      prev_key_in = prev_key_ff;
      acc_key_in  = acc_key_ff;
      deadline_in = deadline_ff;
      emit        = 1'b0;
      out_kind_in = EV_PRESS;
      out_key_in  = seen;
      if (fire && enable_ff) begin
         if (seen != prev_key_ff) begin
            prev_key_in = seen;
         end else if (seen == acc_key_ff) begin
            if (seen != KEY_NONE && reached) begin
               deadline_in = now + TIME_WIDTH'(rep_per_ff);
               emit        = 1'b1;
               out_kind_in = EV_REPEAT;
            end
         end else begin
            acc_key_in = seen;
            emit       = 1'b1;
            if (seen == KEY_NONE) begin
               out_kind_in = EV_RELEASE;
               out_key_in  = KEY_UP;
            end else begin
               deadline_in = now + TIME_WIDTH'(init_dly_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         idle_thr_ff  <= IDLE_THR_RESET;
         tolerance_ff <= TOLERANCE_RESET;
         init_dly_ff  <= INIT_DLY_RESET;
         rep_per_ff   <= REP_PER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_data[0];
            CSR_IDLE_THR:  idle_thr_ff  <= csr_data[MV_BITS-1:0];
            CSR_TOLERANCE: tolerance_ff <= csr_data[TOL_BITS-1:0];
            CSR_INIT_DLY:  init_dly_ff  <= csr_data;
            CSR_REP_PER:   rep_per_ff   <= csr_data;
            default: ;     // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         prev_key_ff <= KEY_NONE;
         acc_key_ff  <= KEY_NONE;
         deadline_ff <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= emit;
         end
         prev_key_ff <= prev_key_in;
         acc_key_ff  <= acc_key_in;
         deadline_ff <= deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         code_ff  <= req_tdata[ADC_BITS-1:0];
         stamp_ff <= req_tdata[ADC_BITS+STAMP_BITS-1:ADC_BITS];
         ok_ff    <= req_tuser;
      end
      if (advance) begin
         out_kind_ff <= out_kind_in;
         out_key_ff  <= out_key_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_key_ff};
   assign rsp_tuser  = out_kind_ff;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the resistor ladder keypad decoder
// Drives ADC poll words, mirrors the debounce, press, repeat and release
// rules in a local decoder model and checks every event word against the
// oldest pending prediction. Directed polls cover every ladder tap, the
// code extremes, failed reads, the wrap-around deadline compare and the
// register masking; random key sessions follow under several settings
// with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import aldk_pkg::*;

   localparam int IDLE_PCT        = 22;
   localparam int RESET_CYCLES    = 11;
   localparam int SETTLE_CYCLES   = 6;     // drain margin past the input and result registers
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int STALL_LIMIT     = 2000;  // well above hold-off plus gaps
   localparam int MAX_PRINTED     = 20;
   localparam int REQ_PAD_BITS    = 48 - STAMP_BITS - ADC_BITS;
   localparam int RSP_PAD_BITS    = 8 - $bits(key_type);

   localparam csr_index_type CSR_SPARE_FIRST = 3'd5;
   localparam csr_index_type CSR_SPARE_LAST  = 3'd7;
   localparam key_type       RELEASE_KEY     = '0;

   typedef struct packed {
      event_type kind;
      key_type   key;
   } key_event_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [47:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   event_type            rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index  = CSR_ENABLE;
   logic [MS_BITS-1:0]   csr_data   = '0;

   // decoder model: registers and state
   logic                 en_cfg;
   logic [MV_BITS-1:0]   idle_mv_cfg;
   logic [TOL_BITS-1:0]  tol_mv_cfg;
   logic [MS_BITS-1:0]   first_delay_cfg;
   logic [MS_BITS-1:0]   period_cfg;
   key_type              last_sample_key;
   key_type              held_key;
   logic [STAMP_BITS-1:0] repeat_due;

   key_event_type        pending_events[$];
   logic [STAMP_BITS-1:0] now_ms;

   bit                   tx_idle_on;
   bit                   rx_idle_on;
   int                   hold_off_cycles;
   int                   stall_cycles;
   int                   mismatches;
   int                   polls_sent;
   int                   regs_written;
   int                   press_seen;
   int                   repeat_seen;
   int                   release_seen;

   adc_ladder_key_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   // Debounce and event rules of the decoder, applied to one accepted poll.
   function automatic void decode_poll(input logic [ADC_BITS-1:0] code, input logic ok,
                                       input logic [STAMP_BITS-1:0] stamp);
      int mv;
      int delta;
      key_type seen;
      key_event_type ev;
      logic [STAMP_BITS-1:0] lag;
      if (en_cfg) begin
         mv = (int'(code) * MV_FULL_SCALE) >> ADC_BITS;
         seen = KEY_NONE;
         if (ok && mv >= int'(idle_mv_cfg)) begin
            for (int i = 0; i < LADDER_TAPS; i++) begin
               delta = mv - int'(LADDER_MV[i]);
               if (delta < 0) delta = -delta;
               if (seen == KEY_NONE && delta <= int'(tol_mv_cfg)) seen = LADDER_KEY[i];
            end
         end
         if (seen != last_sample_key) begin
            last_sample_key = seen;
         end else if (seen == held_key) begin
            lag = stamp - repeat_due;
            // deadline reached when the wrapped difference is not negative
            if (seen != KEY_NONE && !lag[STAMP_BITS-1]) begin
               repeat_due = stamp + STAMP_BITS'(period_cfg);
               ev.kind = EV_REPEAT;
               ev.key = seen;
               pending_events.push_back(ev);
            end
         end else begin
            held_key = seen;
            if (seen == KEY_NONE) begin
               ev.kind = EV_RELEASE;
               ev.key = RELEASE_KEY;
            end else begin
               repeat_due = stamp + STAMP_BITS'(first_delay_cfg);
               ev.kind = EV_PRESS;
               ev.key = seen;
            end
            pending_events.push_back(ev);
         end
      end
   endfunction

   function automatic logic [ADC_BITS-1:0] code_near(input int tap, input int spread);
      int c;
      c = int'(LADDER_MV[tap]) * (1 << ADC_BITS) / MV_FULL_SCALE
          + int'($urandom_range(0, 2 * spread)) - spread;
      if (c < 0) c = 0;
      if (c > (1 << ADC_BITS) - 1) c = (1 << ADC_BITS) - 1;
      return c[ADC_BITS-1:0];
   endfunction

   // Mostly forward steps, now and then a jump or a small step back.
   function automatic void step_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) now_ms = $urandom;
      else if (r < 8) now_ms = now_ms - $urandom_range(1, 50);
      else now_ms = now_ms + $urandom_range(0, 300);
   endfunction

   task automatic send_poll(input logic [ADC_BITS-1:0] code, input logic ok,
                            input logic [STAMP_BITS-1:0] stamp);
      while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_BITS{1'b0}}, stamp, code};
      req_tuser  <= ok;
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_poll(code, ok, stamp);
      polls_sent++;
   endtask

   // Drop valid, wait out every pending event and the pipe latency.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [MS_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ENABLE:    en_cfg = value[0];
         CSR_IDLE_THR:  idle_mv_cfg = value[MV_BITS-1:0];
         CSR_TOLERANCE: tol_mv_cfg = value[TOL_BITS-1:0];
         CSR_INIT_DLY:  first_delay_cfg = value;
         CSR_REP_PER:   period_cfg = value;
         default: ;
      endcase
      regs_written++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic en, input int thr, input int tol,
                             input int first_delay, input int period);
      drain_results();
      write_reg(CSR_ENABLE, MS_BITS'(en));
      write_reg(CSR_IDLE_THR, MS_BITS'(thr));
      write_reg(CSR_TOLERANCE, MS_BITS'(tol));
      write_reg(CSR_INIT_DLY, MS_BITS'(first_delay));
      write_reg(CSR_REP_PER, MS_BITS'(period));
   endtask

   // Key sessions: hold a tap for a few polls, usually release, plus noise.
   task automatic run_sessions(input int polls);
      int done;
      int tap;
      logic [ADC_BITS-1:0] code;
      logic ok;
      done = 0;
      while (done < polls) begin
         if ($urandom_range(0, 99) < 75) begin
            tap = $urandom_range(0, LADDER_TAPS - 1);
            code = code_near(tap, 50);
            repeat ($urandom_range(2, 10)) begin
               step_time();
               send_poll(($urandom_range(0, 99) < 10) ? code_near(tap, 50) : code,
                         1'b1, now_ms);
               done++;
            end
            if ($urandom_range(0, 99) < 70) begin
               repeat ($urandom_range(2, 3)) begin
                  step_time();
                  ok = 1'($urandom_range(0, 1));
                  code = ok ? ADC_BITS'($urandom_range(0, 60))
                            : ADC_BITS'($urandom_range(0, 1023));
                  send_poll(code, ok, now_ms);
                  done++;
               end
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_poll(ADC_BITS'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                         $urandom);
               done++;
            end
         end
      end
   endtask

   task automatic test_disabled_polls();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      now_ms = 32'd1000;
      send_poll(code_near(0, 0), 1'b1, now_ms);
      send_poll(code_near(0, 0), 1'b1, now_ms);
      drain_results();
   endtask

   task automatic test_ladder_taps();
      set_config(1'b1, IDLE_THR_RESET, TOLERANCE_RESET, INIT_DLY_RESET, REP_PER_RESET);
      for (int tap = 0; tap < LADDER_TAPS - 1; tap++) begin
         repeat (2) begin
            now_ms = now_ms + 10;
            send_poll(code_near(tap, 0), 1'b1, now_ms);
         end
      end
      // full-scale code lands on the top tap
      send_poll('1, 1'b1, now_ms);
      send_poll('1, 1'b1, now_ms);
      // failed read and zero code both mean no key
      send_poll(code_near(0, 0), 1'b0, now_ms);
      send_poll('0, 1'b1, now_ms);
      drain_results();
   endtask

   task automatic test_repeat_deadline();
      now_ms = 32'hFFFF_FF00;
      send_poll(code_near(0, 0), 1'b1, now_ms);
      send_poll(code_near(0, 0), 1'b1, now_ms);
      // deadline wraps past zero: one short, then exactly on it
      send_poll(code_near(0, 0), 1'b1, 32'h0000_00F3);
      send_poll(code_near(0, 0), 1'b1, 32'h0000_00F4);
      // half the time range away counts as not yet reached
      send_poll(code_near(0, 0), 1'b1, 32'h8000_0158);
      send_poll('0, 1'b1, 32'h8000_0160);
      send_poll('0, 1'b1, 32'h8000_0170);
      drain_results();
   endtask

   task automatic test_register_masking();
      for (int idx = CSR_SPARE_FIRST; idx <= CSR_SPARE_LAST; idx++) begin
         write_reg(csr_index_type'(idx), '0);
      end
      send_poll(code_near(0, 0), 1'b1, now_ms);
      send_poll(code_near(0, 0), 1'b1, now_ms);
      drain_results();
      write_reg(CSR_IDLE_THR, '1);
      write_reg(CSR_TOLERANCE, '1);
      send_poll('1, 1'b1, now_ms);
      send_poll('1, 1'b1, now_ms);
      drain_results();
      write_reg(CSR_ENABLE, 16'hFFFE);
      send_poll(code_near(3, 0), 1'b1, now_ms);
      send_poll(code_near(3, 0), 1'b1, now_ms);
      drain_results();
   endtask

   task automatic test_random_defaults();
      set_config(1'b1, IDLE_THR_RESET, TOLERANCE_RESET, INIT_DLY_RESET, REP_PER_RESET);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      run_sessions(75);
      drain_results();
      run_sessions(75);
   endtask

   task automatic test_random_fast_repeat();
      set_config(1'b1, 0, 120, 0, 0);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      run_sessions(100);
   endtask

   task automatic test_receiver_hold_off();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      hold_off_cycles = HOLD_OFF_CYCLES;
      run_sessions(40);
   endtask

   task automatic test_random_settings();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (3) begin
         set_config(1'b1, $urandom_range(0, 400), $urandom_range(20, 150),
                    $urandom_range(0, 800), $urandom_range(0, 300));
         run_sessions(70);
      end
   endtask

   task automatic test_extreme_settings();
      set_config(1'b1, 1000, (1 << TOL_BITS) - 1, (1 << MS_BITS) - 1, (1 << MS_BITS) - 1);
      run_sessions(25);
      set_config(1'b1, 0, 0, 0, (1 << MS_BITS) - 1);
      run_sessions(25);
   endtask

   // Receiver side: random idling or a counted hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (rx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_events
      key_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("event word with nothing pending: kind %0d key %0d",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = pending_events.pop_front();
            if (rsp_tuser !== want.kind) begin
               report_mismatch($sformatf("event kind %0d, predicted %0d",
                                         rsp_tuser, want.kind));
            end
            if (rsp_tdata !== {{RSP_PAD_BITS{1'b0}}, want.key}) begin
               report_mismatch($sformatf("key word %0h, predicted key %0d",
                                         rsp_tdata, want.key));
            end
            case (want.kind)
               EV_PRESS:   press_seen++;
               EV_REPEAT:  repeat_seen++;
               default:    release_seen++;
            endcase
         end
      end
   end

   // Watchdog: any handshake clears the count of silent cycles.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles, %0d events pending",
                  stall_cycles, pending_events.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      en_cfg          = 1'b0;
      idle_mv_cfg     = IDLE_THR_RESET;
      tol_mv_cfg      = TOLERANCE_RESET;
      first_delay_cfg = INIT_DLY_RESET;
      period_cfg      = REP_PER_RESET;
      last_sample_key = KEY_NONE;
      held_key        = KEY_NONE;
      repeat_due      = '0;
      hold_off_cycles = 0;
      stall_cycles    = 0;
      mismatches      = 0;
      tx_idle_on      = 1'b1;
      rx_idle_on      = 1'b1;
      now_ms          = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_polls();
      test_ladder_taps();
      test_repeat_deadline();
      test_register_masking();
      test_random_defaults();
      test_random_fast_repeat();
      test_receiver_hold_off();
      test_random_settings();
      test_extreme_settings();
      drain_results();

      $display("covered %0d polls over all ladder taps, failed reads and wrapped deadlines",
               polls_sent);
      $display("checked %0d press, %0d repeat, %0d release events; %0d register writes",
               press_seen, repeat_seen, release_seen, regs_written);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
